@@ rtl/sdrr_pkg.sv @@
`timescale 1ns / 1ps

package sdrr_pkg;

  // Pipelined divider geometry: the remainder is one bit wider than the widest
  // divisor and the quotient is as wide as the widest dividend low part.
  localparam int unsigned DIV_DW = 40;
  localparam int unsigned DIV_QW = 64;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DW    = 39;

  // Largest magnitude of a signed Q40.8 derivative.
  localparam logic [46:0] DMAX = {47{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POP_SIZE     = 3'd0,
    CFG_INCUB_RATE   = 3'd1,
    CFG_RAMP_START   = 3'd2,
    CFG_RAMP_END     = 3'd3,
    CFG_CONTACT_0    = 3'd4,
    CFG_PERIOD_0     = 3'd5,
    CFG_CONTACT_1    = 3'd6,
    CFG_PERIOD_1     = 3'd7
  } cfg_idx_e;

endpackage

@@ rtl/sdrr_div.sv @@
`timescale 1ns / 1ps

// Fully pipelined restoring divider, one quotient bit per stage.
// The high part of the dividend must be below the divisor.
module sdrr_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic [sdrr_pkg::DIV_DW-1:0]     num_hi_i,
  input  logic [sdrr_pkg::DIV_QW-1:0]     num_lo_i,
  input  logic [sdrr_pkg::DIV_DW-1:0]     den_i,
  output logic                            valid_o,
  output logic [sdrr_pkg::DIV_QW-1:0]     quo_o
);

  localparam int unsigned DW = sdrr_pkg::DIV_DW;
  localparam int unsigned QW = sdrr_pkg::DIV_QW;

  logic [DW-1:0] rem_q [QW];
  logic [DW-1:0] rem_d [QW];
  logic [QW-1:0] ql_q  [QW];
  logic [QW-1:0] ql_d  [QW];
  logic [DW-1:0] den_q [QW];
  logic [DW-1:0] den_d [QW];
  logic          vld_q [QW];
  logic          vld_d [QW];

  always_comb begin
    logic [DW-1:0] rin;
    logic [QW-1:0] qin;
    logic [DW-1:0] din;
    logic [DW:0]   trial;
    logic          ge;
    for (int k = 0; k < QW; k++) begin
      if (k == 0) begin
        rin      = num_hi_i;
        qin      = num_lo_i;
        din      = den_i;
        vld_d[k] = valid_i;
      end else begin
        rin      = rem_q[k-1];
        qin      = ql_q[k-1];
        din      = den_q[k-1];
        vld_d[k] = vld_q[k-1];
      end
      trial    = {rin, qin[QW-1]};
      ge       = (trial >= {1'b0, din});
      rem_d[k] = ge ? DW'(trial - {1'b0, din}) : trial[DW-1:0];
      ql_d[k]  = {qin[QW-2:0], ge};
      den_d[k] = din;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < QW; k++) vld_q[k] <= 1'b0;
    end else begin
      for (int k = 0; k < QW; k++) vld_q[k] <= vld_d[k];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < QW; k++) begin
      rem_q[k] <= rem_d[k];
      ql_q[k]  <= ql_d[k];
      den_q[k] <= den_d[k];
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quo_o   = ql_q[QW-1];

endmodule

@@ rtl/seir_derivative_ramped_rates_unit.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// command   in         start_i, busy_o        sim_time_i, susceptible_i, exposed_i,
//                                             infectious_i, removed_i
// result    out        done_o (strobe)        d_susceptible_o, d_exposed_o,
//                                             d_infectious_o, d_removed_o,
//                                             effective_repro_o, basic_repro_o,
//                                             out_of_bounds_o
// config    in         cfg_we_i               cfg_idx_i, cfg_data_i
//
// A word is accepted in every cycle and its result word is on the outputs for one
// cycle under done_o. The pipeline is made of two rounds of 64-stage
// pipelined dividers, first the ramp quotients, then the infection, removal and
// effective reproduction quotients, plus nine register stages around them.
// Reset clears the configuration to its defaults and the pipeline valid bits.
// busy_o is always low and the receiver cannot stall, so the pipeline never stops.
module seir_derivative_ramped_rates_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [31:0]                       sim_time_i,
  input  logic signed [39:0]                susceptible_i,
  input  logic signed [39:0]                exposed_i,
  input  logic signed [39:0]                infectious_i,
  input  logic signed [39:0]                removed_i,
  output logic                              done_o,
  output logic signed [47:0]                d_susceptible_o,
  output logic signed [47:0]                d_exposed_o,
  output logic signed [47:0]                d_infectious_o,
  output logic signed [47:0]                d_removed_o,
  output logic [31:0]                       effective_repro_o,
  output logic [31:0]                       basic_repro_o,
  output logic                              out_of_bounds_o,
  input  logic                              cfg_we_i,
  input  logic [sdrr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sdrr_pkg::CFG_DW-1:0]       cfg_data_i
);

  localparam int unsigned DW = sdrr_pkg::DIV_DW;
  localparam int unsigned QW = sdrr_pkg::DIV_QW;

  // Sideband that rides along the ramp divider.
  typedef struct packed {
    logic        below;
    logic        above;
    logic        span0;
    logic        oob;
    logic [38:0] s;
    logic [38:0] e;
    logic [38:0] i;
  } ramp_sb_t;

  // Sideband that rides along the quotient dividers.
  typedef struct packed {
    logic        oob;
    logic [46:0] onset;
    logic [31:0] basic;
  } quo_sb_t;

  // ---------------------------------------------------------------------------
  // Configuration registers. The user must write these only while the pipeline is
  // empty; the block does not enforce it, and the stages read these directly.
  // ---------------------------------------------------------------------------
  logic [38:0] pop_q;
  logic [31:0] inc_q, rs_q, re_q, cs_q, ps_q, ce_q, pe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_q <= 39'd256;
      inc_q <= 32'd0;
      rs_q  <= 32'd0;
      re_q  <= 32'd0;
      cs_q  <= 32'd0;
      ps_q  <= 32'd65536;
      ce_q  <= 32'd0;
      pe_q  <= 32'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sdrr_pkg::CFG_POP_SIZE:   pop_q <= cfg_data_i;
        sdrr_pkg::CFG_INCUB_RATE: inc_q <= cfg_data_i[31:0];
        sdrr_pkg::CFG_RAMP_START: rs_q  <= cfg_data_i[31:0];
        sdrr_pkg::CFG_RAMP_END:   re_q  <= cfg_data_i[31:0];
        sdrr_pkg::CFG_CONTACT_0:  cs_q  <= cfg_data_i[31:0];
        sdrr_pkg::CFG_PERIOD_0:   ps_q  <= cfg_data_i[31:0];
        sdrr_pkg::CFG_CONTACT_1:  ce_q  <= cfg_data_i[31:0];
        sdrr_pkg::CFG_PERIOD_1:   pe_q  <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // Ramp directions and magnitudes depend on configuration only.
  logic        b_up, p_up;
  logic [31:0] mag_b, mag_p;

  assign b_up  = (ce_q >= cs_q);
  assign p_up  = (pe_q >= ps_q);
  assign mag_b = b_up ? (ce_q - cs_q) : (cs_q - ce_q);
  assign mag_p = p_up ? (pe_q - ps_q) : (ps_q - pe_q);

  assign busy_o = 1'b0;

  // ---------------------------------------------------------------------------
  // Stage 0: capture the command word.
  // ---------------------------------------------------------------------------
  logic        v0_q;
  logic [31:0] t0_q;
  logic [39:0] s0_q, e0_q, i0_q, r0_q;

  // ---------------------------------------------------------------------------
  // Stage 1: bounds check and ramp position.
  // ---------------------------------------------------------------------------
  logic        v1_q;
  ramp_sb_t    sb1_d, sb1_q;
  logic [31:0] dt1_q;

  logic ok_s, ok_e, ok_i, ok_r;

  assign ok_s = !s0_q[39] && (s0_q[38:0] < pop_q);
  assign ok_e = !e0_q[39] && (e0_q[38:0] < pop_q);
  assign ok_i = !i0_q[39] && (i0_q[38:0] < pop_q);
  assign ok_r = !r0_q[39] && (r0_q[38:0] < pop_q);

  always_comb begin
    sb1_d.below = (t0_q < rs_q);
    sb1_d.above = (t0_q > re_q);
    sb1_d.span0 = (re_q == rs_q);
    sb1_d.oob   = !(ok_s && ok_e && ok_i && ok_r);
    sb1_d.s     = s0_q[38:0];
    sb1_d.e     = e0_q[38:0];
    sb1_d.i     = i0_q[38:0];
  end

  // ---------------------------------------------------------------------------
  // Stage 2: ramp numerators, one 32 by 32 product each.
  // ---------------------------------------------------------------------------
  logic        v2_q;
  ramp_sb_t    sb2_q;
  logic [63:0] nb2_q, np2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= start_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t0_q  <= sim_time_i;
    s0_q  <= susceptible_i;
    e0_q  <= exposed_i;
    i0_q  <= infectious_i;
    r0_q  <= removed_i;
    sb1_q <= sb1_d;
    dt1_q <= t0_q - rs_q;
    sb2_q <= sb1_q;
    nb2_q <= dt1_q * mag_b;
    np2_q <= dt1_q * mag_p;
  end

  // ---------------------------------------------------------------------------
  // Ramp dividers, with the sideband delayed alongside them.
  // ---------------------------------------------------------------------------
  logic [DW-1:0] span_den;
  logic          vqb, vqp;
  logic [QW-1:0] qb, qp;
  ramp_sb_t      rsb_q [QW];

  assign span_den = {(DW-32)'(0), re_q - rs_q};

  sdrr_div u_div_beta (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (v2_q),
    .num_hi_i ('0),
    .num_lo_i (nb2_q),
    .den_i    (span_den),
    .valid_o  (vqb),
    .quo_o    (qb)
  );

  sdrr_div u_div_period (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (v2_q),
    .num_hi_i ('0),
    .num_lo_i (np2_q),
    .den_i    (span_den),
    .valid_o  (vqp),
    .quo_o    (qp)
  );

  always_ff @(posedge clk_i) begin
    rsb_q[0] <= sb2_q;
    for (int k = 1; k < QW; k++) rsb_q[k] <= rsb_q[k-1];
  end

  // ---------------------------------------------------------------------------
  // Stage B1: select the ramped beta and infectious period.
  // ---------------------------------------------------------------------------
  ramp_sb_t    rsb;
  logic [31:0] beta_d, per_d, per_raw;

  assign rsb = rsb_q[QW-1];

  always_comb begin
    if (rsb.below || (!rsb.above && rsb.span0)) begin
      beta_d  = cs_q;
      per_raw = ps_q;
    end else if (rsb.above) begin
      beta_d  = ce_q;
      per_raw = pe_q;
    end else begin
      beta_d  = b_up ? (cs_q + qb[31:0]) : (cs_q - qb[31:0]);
      per_raw = p_up ? (ps_q + qp[31:0]) : (ps_q - qp[31:0]);
    end
    // A zero period counts as the smallest step.
    per_d = (per_raw == 32'd0) ? 32'd1 : per_raw;
  end

  logic        vb1_q, vb2_q, vb3_q, vb4_q, vb5_q;
  logic        oob1_q, oob2_q, oob3_q, oob4_q, oob5_q;
  logic [31:0] beta1_q, beta2_q, beta3_q;
  logic [31:0] per1_q, per2_q, per3_q, per4_q, per5_q;
  logic [38:0] s1_q, s2_q;
  logic [38:0] e1_q;
  logic [38:0] i1_q, i2_q, i3_q, i4_q, i5_q;

  // Stage B2 products.
  logic [63:0] pb2_q;
  logic [63:0] is_ll_q;
  logic [38:0] is_lh_q, is_hl_q;
  logic [13:0] is_hh_q;
  logic [63:0] on_l_q;
  logic [38:0] on_h_q;

  // Stage B3: sums and the next partial products.
  logic [77:0] is3_q;
  logic [70:0] onp3_q;
  logic [63:0] pb3_q;
  logic [63:0] pbs_ll_q, pbs_hl_q;
  logic [38:0] pbs_lh_q, pbs_hh_q;

  // Stage B4.
  logic [102:0] pbs4_q;
  logic [63:0]  isb0_q, isb1_q;
  logic [45:0]  isb2_q;
  logic [46:0]  onset4_q;
  logic [31:0]  basic4_q;

  // Stage B5.
  logic [109:0] isb5_q;
  logic [102:0] pbs5_q;
  logic [46:0]  onset5_q;
  logic [31:0]  basic5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb1_q <= 1'b0;
      vb2_q <= 1'b0;
      vb3_q <= 1'b0;
      vb4_q <= 1'b0;
      vb5_q <= 1'b0;
    end else begin
      vb1_q <= vqb && vqp;
      vb2_q <= vb1_q;
      vb3_q <= vb2_q;
      vb4_q <= vb3_q;
      vb5_q <= vb4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    // B1
    beta1_q <= beta_d;
    per1_q  <= per_d;
    oob1_q  <= rsb.oob;
    s1_q    <= rsb.s;
    e1_q    <= rsb.e;
    i1_q    <= rsb.i;
    // B2: the 39-bit operands are split at bit 32.
    pb2_q   <= per1_q * beta1_q;
    is_ll_q <= i1_q[31:0] * s1_q[31:0];
    is_lh_q <= i1_q[31:0] * s1_q[38:32];
    is_hl_q <= i1_q[38:32] * s1_q[31:0];
    is_hh_q <= i1_q[38:32] * s1_q[38:32];
    on_l_q  <= inc_q * e1_q[31:0];
    on_h_q  <= inc_q * e1_q[38:32];
    beta2_q <= beta1_q;
    per2_q  <= per1_q;
    oob2_q  <= oob1_q;
    s2_q    <= s1_q;
    i2_q    <= i1_q;
    // B3
    is3_q    <= 78'(is_ll_q) + (78'(is_lh_q) << 32) + (78'(is_hl_q) << 32)
              + (78'(is_hh_q) << 64);
    onp3_q   <= 71'(on_l_q) + (71'(on_h_q) << 32);
    pb3_q    <= pb2_q;
    pbs_ll_q <= pb2_q[31:0] * s2_q[31:0];
    pbs_lh_q <= pb2_q[31:0] * s2_q[38:32];
    pbs_hl_q <= pb2_q[63:32] * s2_q[31:0];
    pbs_hh_q <= pb2_q[63:32] * s2_q[38:32];
    beta3_q  <= beta2_q;
    per3_q   <= per2_q;
    oob3_q   <= oob2_q;
    i3_q     <= i2_q;
    // B4
    pbs4_q   <= 103'(pbs_ll_q) + (103'(pbs_lh_q) << 32) + (103'(pbs_hl_q) << 32)
              + (103'(pbs_hh_q) << 64);
    isb0_q   <= is3_q[31:0] * beta3_q;
    isb1_q   <= is3_q[63:32] * beta3_q;
    isb2_q   <= is3_q[77:64] * beta3_q;
    onset4_q <= onp3_q[70:24];
    basic4_q <= (pb3_q[63:56] != 8'd0) ? 32'hFFFF_FFFF : pb3_q[55:24];
    per4_q   <= per3_q;
    oob4_q   <= oob3_q;
    i4_q     <= i3_q;
    // B5
    isb5_q   <= 110'(isb0_q) + (110'(isb1_q) << 32) + (110'(isb2_q) << 64);
    pbs5_q   <= pbs4_q;
    onset5_q <= onset4_q;
    basic5_q <= basic4_q;
    per5_q   <= per4_q;
    oob5_q   <= oob4_q;
    i5_q     <= i4_q;
  end

  // ---------------------------------------------------------------------------
  // Quotient dividers: infection, removal and effective reproduction.
  // The Q8.24 rate scaling is dropped from the dividend before dividing by N.
  // ---------------------------------------------------------------------------
  logic [DW-1:0] pop_den, per_den;
  logic          vqi, vqr, vqe;
  logic [QW-1:0] qi, qr, qe;
  quo_sb_t       qsb_q [QW];

  assign pop_den = {(DW-39)'(0), pop_q};
  assign per_den = {(DW-32)'(0), per5_q};

  sdrr_div u_div_infection (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (vb5_q),
    .num_hi_i ({(DW-22)'(0), isb5_q[109:88]}),
    .num_lo_i (isb5_q[87:24]),
    .den_i    (pop_den),
    .valid_o  (vqi),
    .quo_o    (qi)
  );

  sdrr_div u_div_removal (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (vb5_q),
    .num_hi_i ('0),
    .num_lo_i ({(QW-55)'(0), i5_q, 16'd0}),
    .den_i    (per_den),
    .valid_o  (vqr),
    .quo_o    (qr)
  );

  sdrr_div u_div_effective (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (vb5_q),
    .num_hi_i ({(DW-15)'(0), pbs5_q[102:88]}),
    .num_lo_i (pbs5_q[87:24]),
    .den_i    (pop_den),
    .valid_o  (vqe),
    .quo_o    (qe)
  );

  always_ff @(posedge clk_i) begin
    qsb_q[0] <= '{oob: oob5_q, onset: onset5_q, basic: basic5_q};
    for (int k = 1; k < QW; k++) qsb_q[k] <= qsb_q[k-1];
  end

  // ---------------------------------------------------------------------------
  // Final stage: combine, saturate and register the result word.
  // The infection quotient is always below 2^47 for in-bounds compartments.
  // ---------------------------------------------------------------------------
  quo_sb_t     qsb;
  logic [46:0] infection, removal;
  logic [31:0] eff;

  assign qsb       = qsb_q[QW-1];
  assign infection = qi[46:0];
  assign removal   = (qr[63:47] != 17'd0) ? sdrr_pkg::DMAX : qr[46:0];
  assign eff       = (qe[63:32] != 32'd0) ? 32'hFFFF_FFFF : qe[31:0];

  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vqi && vqr && vqe;
    end
  end

  always_ff @(posedge clk_i) begin
    out_of_bounds_o <= qsb.oob;
    if (qsb.oob) begin
      d_susceptible_o   <= '0;
      d_exposed_o       <= '0;
      d_infectious_o    <= '0;
      d_removed_o       <= '0;
      effective_repro_o <= '0;
      basic_repro_o     <= '0;
    end else begin
      d_susceptible_o   <= 48'sd0 - $signed({1'b0, infection});
      d_exposed_o       <= $signed({1'b0, infection}) - $signed({1'b0, qsb.onset});
      d_infectious_o    <= $signed({1'b0, qsb.onset}) - $signed({1'b0, removal});
      d_removed_o       <= $signed({1'b0, removal});
      effective_repro_o <= eff;
      basic_repro_o     <= qsb.basic;
    end
  end

  assign done_o = done_q;

`ifndef SYNTHESIS
  // Out-of-bounds words carry all-zero results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && out_of_bounds_o |-> d_susceptible_o == 0 && d_exposed_o == 0
      && d_infectious_o == 0 && d_removed_o == 0 && effective_repro_o == 0
      && basic_repro_o == 0)
    else $error("out-of-bounds result is not zero");

  // The four flows conserve the population.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> 48'(d_susceptible_o + d_exposed_o + d_infectious_o + d_removed_o)
      == 48'd0)
    else $error("derivatives do not sum to zero");

  // The susceptible share is below one, so R_eff never exceeds R_0.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> effective_repro_o <= basic_repro_o)
    else $error("effective reproduction exceeds basic reproduction");

  // A valid word from the ramp dividers reaches the quotient dividers after
  // passing through stages B1 to B5.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vqb |-> ##5 vb5_q)
    else $error("pipeline valid lost between the dividers");
`endif

endmodule

@@ sim/seir_derivative_ramped_rates_unit_tb.sv @@
`timescale 1ns / 1ps

module seir_derivative_ramped_rates_unit_tb;

  // Timeout bound for the whole run, with ample room to spare.
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Settling wait after the last phase, before the final check of outstanding results.
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned PHASE_WORDS = 225;
  localparam logic [63:0] DERIV_MAX = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] DERIV_MIN = -64'sh0000_8000_0000_0000;

  // One command word: a time point and the four compartment sizes.
  typedef struct packed {
    logic [31:0] sim_time;
    logic [39:0] susceptible;
    logic [39:0] exposed;
    logic [39:0] infectious;
    logic [39:0] removed;
  } seir_point_t;

  // One result word: derivatives, reproduction numbers and the bounds flag.
  typedef struct packed {
    logic [47:0] d_s;
    logic [47:0] d_e;
    logic [47:0] d_i;
    logic [47:0] d_r;
    logic [31:0] eff;
    logic [31:0] basic;
    logic        oob;
  } seir_rates_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [31:0] sim_time_i = '0;
  logic signed [39:0] susceptible_i = '0;
  logic signed [39:0] exposed_i = '0;
  logic signed [39:0] infectious_i = '0;
  logic signed [39:0] removed_i = '0;
  logic done_o;
  logic signed [47:0] d_susceptible_o;
  logic signed [47:0] d_exposed_o;
  logic signed [47:0] d_infectious_o;
  logic signed [47:0] d_removed_o;
  logic [31:0] effective_repro_o;
  logic [31:0] basic_repro_o;
  logic out_of_bounds_o;
  logic cfg_we_i = 1'b0;
  logic [sdrr_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [sdrr_pkg::CFG_DW-1:0] cfg_data_i = '0;

  seir_derivative_ramped_rates_unit DUT (.*);

  always #10 clk_i = ~clk_i;

  // Our own copy of the configuration, kept in step with every register write.
  logic [38:0] pop_size_q;
  logic [31:0] incub_rate_q;
  logic [31:0] ramp_start_q;
  logic [31:0] ramp_end_q;
  logic [31:0] contact_0_q;
  logic [31:0] period_0_q;
  logic [31:0] contact_1_q;
  logic [31:0] period_1_q;

  seir_point_t pending_points[$];
  seir_rates_t expected_rates[$];
  int unsigned sender_idle_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned oob_seen = 0;
  int unsigned error_count = 0;

  // Linear ramp between the start and end times. The step is truncated toward
  // the start value, and an empty interval hitting t exactly keeps the start value.
  function automatic logic [31:0] ramp_value(logic [31:0] t, logic [31:0] v0,
                                             logic [31:0] v1);
    logic [63:0] span, dt, mag, step;
    if (t < ramp_start_q) return v0;
    if (t > ramp_end_q) return v1;
    span = 64'(ramp_end_q) - 64'(ramp_start_q);
    if (span == 0) return v0;
    dt = 64'(t) - 64'(ramp_start_q);
    mag = (v1 >= v0) ? 64'(v1 - v0) : 64'(v0 - v1);
    step = (dt * mag) / span;
    return (v1 >= v0) ? v0 + step[31:0] : v0 - step[31:0];
  endfunction

  // Computes the SEIR right-hand side for one point under the current settings.
  function automatic seir_rates_t seir_rates(seir_point_t p);
    seir_rates_t res;
    logic [127:0] den, prod, quot;
    logic [63:0] beta, per, infection, onset, removal, rem;
    logic signed [63:0] di;
    res = '0;
    if (p.susceptible[39] || p.exposed[39] || p.infectious[39] || p.removed[39] ||
        p.susceptible[38:0] >= pop_size_q || p.exposed[38:0] >= pop_size_q ||
        p.infectious[38:0] >= pop_size_q || p.removed[38:0] >= pop_size_q) begin
      res.oob = 1'b1;
      return res;
    end
    beta = 64'(ramp_value(p.sim_time, contact_0_q, contact_1_q));
    per = 64'(ramp_value(p.sim_time, period_0_q, period_1_q));
    if (per == 0) per = 1;
    den = 128'(pop_size_q) << 24;

    prod = 128'(beta) * 128'(p.infectious[38:0]) * 128'(p.susceptible[38:0]);
    quot = prod / den;
    infection = (quot > 128'(DERIV_MAX)) ? DERIV_MAX : quot[63:0];

    prod = 128'(incub_rate_q) * 128'(p.exposed[38:0]);
    quot = prod >> 24;
    onset = (quot > 128'(DERIV_MAX)) ? DERIV_MAX : quot[63:0];

    removal = (64'(p.infectious[38:0]) << 16) / per;
    rem = (removal > DERIV_MAX) ? DERIV_MAX : removal;
    di = $signed(onset) - $signed(rem);
    if (di < DERIV_MIN) di = DERIV_MIN;

    res.d_s = 48'(-$signed(infection));
    res.d_e = 48'($signed(infection) - $signed(onset));
    res.d_i = di[47:0];
    res.d_r = rem[47:0];

    prod = 128'(per) * 128'(beta) * 128'(p.susceptible[38:0]);
    quot = prod / den;
    res.eff = (quot > 128'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : quot[31:0];
    prod = 128'(per) * 128'(beta);
    quot = prod >> 24;
    res.basic = (quot > 128'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : quot[31:0];
    return res;
  endfunction

  task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Registers are written at the falling edge; the caller lowers the enable.
  task automatic write_reg(sdrr_pkg::cfg_idx_e idx, logic [38:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    case (idx)
      sdrr_pkg::CFG_POP_SIZE:   pop_size_q = value;
      sdrr_pkg::CFG_INCUB_RATE: incub_rate_q = value[31:0];
      sdrr_pkg::CFG_RAMP_START: ramp_start_q = value[31:0];
      sdrr_pkg::CFG_RAMP_END:   ramp_end_q = value[31:0];
      sdrr_pkg::CFG_CONTACT_0:  contact_0_q = value[31:0];
      sdrr_pkg::CFG_PERIOD_0:   period_0_q = value[31:0];
      sdrr_pkg::CFG_CONTACT_1:  contact_1_q = value[31:0];
      sdrr_pkg::CFG_PERIOD_1:   period_1_q = value[31:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [38:0] pop, logic [31:0] incub, logic [31:0] r0,
                           logic [31:0] r1, logic [31:0] c0, logic [31:0] p0,
                           logic [31:0] c1, logic [31:0] p1);
    write_reg(sdrr_pkg::CFG_POP_SIZE, pop);
    write_reg(sdrr_pkg::CFG_INCUB_RATE, 39'(incub));
    write_reg(sdrr_pkg::CFG_RAMP_START, 39'(r0));
    write_reg(sdrr_pkg::CFG_RAMP_END, 39'(r1));
    write_reg(sdrr_pkg::CFG_CONTACT_0, 39'(c0));
    write_reg(sdrr_pkg::CFG_PERIOD_0, 39'(p0));
    write_reg(sdrr_pkg::CFG_CONTACT_1, 39'(c1));
    write_reg(sdrr_pkg::CFG_PERIOD_1, 39'(p1));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Compartments are mostly inside the population, with edge values and
  // arbitrary 40-bit patterns (negative ones among them) mixed in.
  function automatic logic [39:0] rand_compartment();
    logic [63:0] r;
    int unsigned pick;
    r = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 75) return 40'(r % 64'(pop_size_q));
    if (pick < 80) return 40'(r[38:0] >> $urandom_range(38)) % 40'(pop_size_q);
    if (pick < 84) return 40'(pop_size_q) - 40'd1;
    if (pick < 87) return 40'(pop_size_q);
    if (pick < 90) return 40'd0;
    return r[39:0];
  endfunction

  function automatic logic [31:0] rand_time();
    case ($urandom_range(7))
      0: return ramp_start_q;
      1: return ramp_end_q;
      2: return ramp_start_q - 32'd1;
      3: return ramp_end_q + 32'd1;
      4: return $urandom;
      default: begin
        if (ramp_end_q > ramp_start_q)
          return ramp_start_q + ($urandom % (ramp_end_q - ramp_start_q + 32'd1));
        return $urandom;
      end
    endcase
  endfunction

  task automatic queue_point(logic [31:0] t, logic [39:0] s, logic [39:0] e,
                             logic [39:0] i, logic [39:0] r);
    pending_points.push_back('{t, s, e, i, r});
  endtask

  // Waits until every queued word has been sent and its result checked.
  task automatic drain();
    wait (pending_points.size() == 0);
    @(posedge clk_i);
    #1;
    wait (expected_rates.size() == 0);
  endtask

  // Driver: presents a word at the falling edge unless the sender idles.
  always @(negedge clk_i) begin
    if (rst_ni && pending_points.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
      seir_point_t p;
      p = pending_points.pop_front();
      start_i <= 1'b1;
      sim_time_i <= p.sim_time;
      susceptible_i <= p.susceptible;
      exposed_i <= p.exposed;
      infectious_i <= p.infectious;
      removed_i <= p.removed;
    end else begin
      start_i <= 1'b0;
    end
  end

  // Monitor: predicts on acceptance and checks each strobed result word.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("seir_derivative_ramped_rates_unit_tb NOT OK");
      $finish;
    end else if (rst_ni) begin
      if (start_i && !busy_o) begin
        expected_rates.push_back(seir_rates('{sim_time_i, susceptible_i, exposed_i,
                                              infectious_i, removed_i}));
        words_sent++;
      end
      if (done_o) begin
        if (expected_rates.size() == 0) begin
          error_count++;
          $display("%0t ns: result word with no expectation pending", $time);
        end else begin
          seir_rates_t want;
          want = expected_rates.pop_front();
          check_field("d_susceptible", want.d_s, d_susceptible_o);
          check_field("d_exposed", want.d_e, d_exposed_o);
          check_field("d_infectious", want.d_i, d_infectious_o);
          check_field("d_removed", want.d_r, d_removed_o);
          check_field("effective_repro", 48'(want.eff), 48'(effective_repro_o));
          check_field("basic_repro", 48'(want.basic), 48'(basic_repro_o));
          check_field("out_of_bounds", 48'(want.oob), 48'(out_of_bounds_o));
          words_checked++;
          if (want.oob) oob_seen++;
        end
      end
    end
  end

  initial begin
    // Reset values of the configuration: population 1.0, both periods 1.0.
    pop_size_q = 39'd256;
    incub_rate_q = '0;
    ramp_start_q = '0;
    ramp_end_q = '0;
    contact_0_q = '0;
    period_0_q = 32'd65536;
    contact_1_q = '0;
    period_1_q = 32'd65536;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed words under the reset configuration: empty and full
    // compartments, the population edge, negative and extreme patterns.
    queue_point(32'd0, 40'd0, 40'd0, 40'd0, 40'd0);
    queue_point(32'hFFFF_FFFF, 40'd255, 40'd255, 40'd255, 40'd255);
    queue_point(32'd0, 40'd256, 40'd0, 40'd0, 40'd0);
    queue_point(32'd0, 40'd0, 40'd0, 40'd0, 40'd256);
    queue_point(32'd0, 40'hFF_FFFF_FFFF, 40'd0, 40'd0, 40'd0);
    queue_point(32'd0, 40'd0, 40'h80_0000_0000, 40'd0, 40'd0);
    queue_point(32'd0, 40'd0, 40'd0, 40'h7F_FFFF_FFFF, 40'd0);
    queue_point(32'd5, 40'd100, 40'd0, 40'd0, 40'd3);
    drain();

    // Largest population and rates: exercises saturation of both reproduction numbers.
    write_all(39'h7F_FFFF_FFFF, 32'hFFFF_FFFF, 32'd1000, 32'd2000, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_point(32'd0, 40'h7F_FFFF_FFFE, 40'h7F_FFFF_FFFE, 40'h7F_FFFF_FFFE, 40'd0);
    queue_point(32'd3000, 40'h7F_FFFF_FFFE, 40'd0, 40'h7F_FFFF_FFFE, 40'h7F_FFFF_FFFE);
    queue_point(32'd1500, 40'd0, 40'h7F_FFFF_FFFE, 40'd0, 40'd1);
    drain();

    // Falling ramp with the smallest period: truncation toward the start value
    // and the shortest legal infectious period.
    write_all(39'd1, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd0,
              32'd1);
    queue_point(32'd0, 40'd0, 40'd0, 40'd0, 40'd0);
    queue_point(32'h8000_0000, 40'd0, 40'd0, 40'd0, 40'd0);
    queue_point(32'hFFFF_FFFF, 40'd1, 40'd0, 40'd0, 40'd0);
    drain();

    // Random phases cycle through the sender idling modes. Some phases use
    // an empty ramp interval or an inverted one.
    for (int ph = 0; ph < 8; ph++) begin
      logic [38:0] pop;
      logic [31:0] r0, r1;
      pop = ($urandom_range(3) == 0) ? 39'($urandom_range(4000, 1))
                                     : 39'({$urandom, $urandom}) | 39'd1;
      r0 = $urandom;
      case (ph % 3)
        0: r1 = r0;
        1: r1 = r0 - $urandom_range(5000);
        default: r1 = r0 + $urandom_range(200000);
      endcase
      write_all(pop, $urandom >> $urandom_range(31), r0, r1, $urandom >> $urandom_range(31),
                ($urandom >> $urandom_range(31)) | 32'd1, $urandom >> $urandom_range(31),
                ($urandom >> $urandom_range(31)) | 32'd1);
      case (ph % 4)
        0: sender_idle_pct = 0;
        1: sender_idle_pct = 62;
        2: sender_idle_pct = 0;
        default: sender_idle_pct = 9;
      endcase
      for (int n = 0; n < PHASE_WORDS; n++)
        queue_point(rand_time(), rand_compartment(), rand_compartment(),
                    rand_compartment(), rand_compartment());
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_rates.size() != 0) begin
      error_count++;
      $display("%0t ns: %0d expected results never arrived", $time, expected_rates.size());
    end
    $display("Sent %0d command words, checked %0d results (%0d out of bounds),",
             words_sent, words_checked, oob_seen);
    $display("over 11 configurations with rising, falling, empty and inverted ramps.");
    if (error_count == 0) begin
      $display("seir_derivative_ramped_rates_unit_tb OK");
    end else begin
      $display("seir_derivative_ramped_rates_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
